>>> hdl/rbfb_pkg.sv
// ============================================================================
// rbfb_pkg
// Shared types and constants for the rotated bit-plane framebuffer core:
// beat payload structs, operation codes, register indexes, panel defaults.
// ============================================================================
package rbfb_pkg;

    // Default panel geometry in pixels
    localparam int PANEL_WIDTH_DEF  = 200;
    localparam int PANEL_HEIGHT_DEF = 200;

    // Operation codes carried in the op field
    localparam logic [1:0] OP_DRAW = 2'd0;
    localparam logic [1:0] OP_FILL = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // Configuration register indexes
    localparam int         CFG_IDX_W     = 1;
    localparam logic [0:0] CFG_ROTATION  = 1'b0;
    localparam logic [0:0] CFG_MONO_MODE = 1'b1;
    localparam int         CFG_DATA_W    = 2;

    // Command beat
    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        color;
        logic [12:0]        byte_addr;
    } t_in_item;

    // Result beat
    typedef struct packed {
        logic       in_bounds;
        logic [7:0] plane_a_byte;
        logic [7:0] plane_b_byte;
    } t_out_item;

endpackage

>>> hdl/rotated_bitplane_framebuffer_core.sv
// ============================================================================
// rotated_bitplane_framebuffer_core
// Packed e-paper framebuffer with one mono plane and two gray planes.
// Draws one pixel by read-modify-write, fills the buffer, reads a byte back.
//
//   channel | direction | handshake                  | beat
//   --------+-----------+----------------------------+-----------------------
//   in      | to core   | i_in_valid / o_in_stall    | t_in_item command
//   out     | from core | o_out_valid / i_out_stall  | t_out_item result
//   cfg     | to core   | i_cfg_valid / o_cfg_ready  | index + data write
//
// A fill writes one byte per cycle through the RAM write port.
// After reset a clearing pass over all BUF_BYTES bytes (5000 at 200 x 200) sets
// the planes to white; commands stall until it ends, config writes go in.
// One command is in flight at a time; a result waiting in the output register
// does not block the next command until that one needs to deliver.
// ============================================================================
module rotated_bitplane_framebuffer_core
    import rbfb_pkg::*;
#(
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ROW_BYTES = (PANEL_WIDTH + 7) / 8;
    localparam int BUF_BYTES = ROW_BYTES * PANEL_HEIGHT;
    localparam int AW        = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
    localparam int MAXDIM    = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
    localparam int CW        = $clog2(MAXDIM);

    // Sequencer state codes
    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_ADR  = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_FILL = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    localparam logic [AW-1:0] LAST_ADDR = AW'(BUF_BYTES - 1);

    logic [2:0]      r_state, n_state;
    logic [AW-1:0]   r_cnt, n_cnt;
    t_in_item        r_item, n_item;
    logic [1:0]      r_rot, n_rot;
    logic            r_mono, n_mono;
    logic [CW-1:0]   r_px, n_px;
    logic [CW-1:0]   r_py, n_py;
    logic [AW-1:0]   r_idx, n_idx;
    logic            r_rd_oob, n_rd_oob;
    logic            r_out_valid, n_out_valid;
    t_out_item       r_out, n_out;
    t_out_item       r_res, n_res;

    logic            out_free;
    logic            x_ok, y_ok;
    logic [15:0]     lw, lh;
    logic [CW-1:0]   xc, yc, px_calc, py_calc;
    logic [AW-1:0]   idx_calc;
    logic [7:0]      mask;
    logic [1:0]      draw_code, fill_code;

    logic            mono_we, gray_we, ram_re;
    logic [AW-1:0]   waddr, raddr;
    logic [7:0]      mono_wdata, mono_rdata;
    logic [15:0]     gray_wdata, gray_rdata;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;

    // Bounds check against the logical panel, sides swap on odd turns
    assign lw   = r_rot[0] ? 16'(PANEL_HEIGHT) : 16'(PANEL_WIDTH);
    assign lh   = r_rot[0] ? 16'(PANEL_WIDTH)  : 16'(PANEL_HEIGHT);
    assign x_ok = !r_item.x[15] && ($unsigned(r_item.x) < lw);
    assign y_ok = !r_item.y[15] && ($unsigned(r_item.y) < lh);
    assign xc   = r_item.x[CW-1:0];
    assign yc   = r_item.y[CW-1:0];

    // Rotate logical coordinates into physical column and row
    always_comb begin
        unique case (r_rot)
            2'd1: begin
                px_calc = CW'(PANEL_WIDTH - 1) - yc;
                py_calc = xc;
            end
            2'd2: begin
                px_calc = CW'(PANEL_WIDTH - 1) - xc;
                py_calc = CW'(PANEL_HEIGHT - 1) - yc;
            end
            2'd3: begin
                px_calc = yc;
                py_calc = CW'(PANEL_HEIGHT - 1) - xc;
            end
            default: begin
                px_calc = xc;
                py_calc = yc;
            end
        endcase
    end

    // Byte address and MSB-first bit mask of the physical pixel
    assign idx_calc = AW'(32'(r_py) * 32'(ROW_BYTES)) + AW'(r_px >> 3);
    assign mask     = 8'h80 >> r_px[2:0];

    // Gray codes: draw takes color>>6 (0 above 255), fill maps the extremes first
    assign draw_code = (r_item.color[15:8] == 8'd0) ? r_item.color[7:6] : 2'd0;
    assign fill_code = (r_item.color == 16'd255) ? 2'd3 :
                       (r_item.color == 16'd0)   ? 2'd0 : draw_code;

    // Sequencer and datapath
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_item      = r_item;
        n_rot       = r_rot;
        n_mono      = r_mono;
        n_px        = r_px;
        n_py        = r_py;
        n_idx       = r_idx;
        n_rd_oob    = r_rd_oob;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_res       = r_res;
        mono_we     = 1'b0;
        gray_we     = 1'b0;
        ram_re      = 1'b0;
        waddr       = r_idx;
        raddr       = idx_calc;
        mono_wdata  = mono_rdata;
        gray_wdata  = gray_rdata;

        // Drop the result beat once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // Register writes
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROTATION:  n_rot  = i_cfg_data;
                CFG_MONO_MODE: n_mono = i_cfg_data[0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_CLR: begin
                mono_we    = 1'b1;
                gray_we    = 1'b1;
                waddr      = r_cnt;
                mono_wdata = 8'h00;
                gray_wdata = 16'hFFFF;
                n_cnt      = r_cnt + AW'(1);
                if (r_cnt == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_res = '{in_bounds: 1'b1, plane_a_byte: 8'h00, plane_b_byte: 8'h00};
                case (r_item.op)
                    OP_DRAW: begin
                        if (x_ok && y_ok) begin
                            n_px    = px_calc;
                            n_py    = py_calc;
                            n_state = S_ADR;
                        end else begin
                            n_res.in_bounds = 1'b0;
                            n_state         = S_DONE;
                        end
                    end
                    OP_FILL: begin
                        n_cnt   = '0;
                        n_state = S_FILL;
                    end
                    OP_READ: begin
                        ram_re   = 1'b1;
                        raddr    = AW'(r_item.byte_addr);
                        n_rd_oob = (32'(r_item.byte_addr) >= 32'(BUF_BYTES));
                        n_state  = S_RD;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_ADR: begin
                ram_re  = 1'b1;
                n_idx   = idx_calc;
                n_state = S_RD;
            end
            S_RD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_item.op == OP_DRAW) begin
                        n_out = '{in_bounds: 1'b1, plane_a_byte: 8'h00, plane_b_byte: 8'h00};
                        // Modify one bit and write the byte back
                        if (r_mono) begin
                            mono_we    = 1'b1;
                            mono_wdata = (r_item.color != 16'd0) ? (mono_rdata & ~mask)
                                                                 : (mono_rdata | mask);
                        end else begin
                            gray_we           = 1'b1;
                            gray_wdata[7:0]   = draw_code[0] ? (gray_rdata[7:0] | mask)
                                                             : (gray_rdata[7:0] & ~mask);
                            gray_wdata[15:8]  = draw_code[1] ? (gray_rdata[15:8] | mask)
                                                             : (gray_rdata[15:8] & ~mask);
                        end
                    end else begin
                        n_out.in_bounds = 1'b1;
                        if (r_rd_oob) begin
                            n_out.plane_a_byte = 8'hFF;
                            n_out.plane_b_byte = 8'hFF;
                        end else if (r_mono) begin
                            n_out.plane_a_byte = ~mono_rdata;
                            n_out.plane_b_byte = 8'hFF;
                        end else begin
                            n_out.plane_a_byte = ~gray_rdata[7:0];
                            n_out.plane_b_byte = ~gray_rdata[15:8];
                        end
                    end
                end
            end
            S_FILL: begin
                waddr      = r_cnt;
                mono_we    = r_mono;
                gray_we    = !r_mono;
                mono_wdata = (r_item.color == 16'd0) ? 8'hFF : 8'h00;
                gray_wdata = {{8{fill_code[1]}}, {8{fill_code[0]}}};
                n_cnt      = r_cnt + AW'(1);
                if (r_cnt == LAST_ADDR) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_cnt       <= '0;
            r_rot       <= 2'd0;
            r_mono      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_rot       <= n_rot;
            r_mono      <= n_mono;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_px     <= n_px;
        r_py     <= n_py;
        r_idx    <= n_idx;
        r_rd_oob <= n_rd_oob;
        r_out    <= n_out;
        r_res    <= n_res;
    end

    // Mono plane
    rbfb_ram #(
        .WIDTH (8),
        .DEPTH (BUF_BYTES)
    ) u_mono_ram (
        .i_clk   (i_clk),
        .i_we    (mono_we),
        .i_waddr (waddr),
        .i_wdata (mono_wdata),
        .i_re    (ram_re),
        .i_raddr (raddr),
        .o_rdata (mono_rdata)
    );

    // Gray planes, high plane in the upper byte
    rbfb_ram #(
        .WIDTH (16),
        .DEPTH (BUF_BYTES)
    ) u_gray_ram (
        .i_clk   (i_clk),
        .i_we    (gray_we),
        .i_waddr (waddr),
        .i_wdata (gray_wdata),
        .i_re    (ram_re),
        .i_raddr (raddr),
        .o_rdata (gray_rdata)
    );

endmodule

>>> hdl/rbfb_ram.sv
// ============================================================================
// rbfb_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered and held while no read is enabled.
// ============================================================================
module rbfb_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
